// ===== design/sorted_box_collision_table_core_defines.svh =====
// assertion macros for the sorted box collision table core
// used by the checker bound to the top level, no other dependencies
`ifndef SORTED_BOX_COLLISION_TABLE_CORE_DEFINES_SVH
`define SORTED_BOX_COLLISION_TABLE_CORE_DEFINES_SVH

// antecedent holds, consequent must hold on the following edge
`define SBCT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// antecedent holds, consequent must hold on the same edge
`define SBCT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/sbct_pkg.sv =====
// shared types and codes for the sorted box collision table
// no dependencies; imported by the core, the compare unit and the checker
`default_nettype none

package sbct_pkg;

  localparam int DEF_TABLE_DEPTH = 64;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_DUPLICATE = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_HIT       = 3'd3;
  localparam logic [2:0] STAT_NO_HIT    = 3'd4;

  // one stored box
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        w;
    logic [30:0]        h;
    logic [7:0]         typ;
    logic [15:0]        id;
  } entry_t;

  // request box with its right and bottom edges precomputed
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [32:0] xr;
    logic signed [32:0] yb;
    logic [7:0]         typ;
    logic [15:0]        id;
  } probe_t;

  typedef struct packed {
    logic id_eq;
    logic type_eq;
    logic x_le;
    logic past_right;
    logic overlap;
  } cmp_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_QRY_SCAN
  } state_t;

endpackage

`default_nettype wire

// ===== design/sorted_box_collision_table_core.sv =====
// insert: duplicate scan of the held entries, then a top-down shift above the slot;
// query: one entry per cycle from start_index; result in the cycle after acceptance
//   when start is at or past count
// one request at a time (busy high meanwhile, not for a query at or past count; next one taken while
//   done is high); done lasts one cycle and cannot be held off; synchronous reset empties the table, contents kept
`default_nettype none

module sorted_box_collision_table_core
  import sbct_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // request side
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               func,
  input  wire logic [15:0]        obj_id,
  input  wire logic [7:0]         obj_type,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic [30:0]        box_w,
  input  wire logic [30:0]        box_h,
  input  wire logic [5:0]         start_index,
  // result side
  output logic                    done,
  output logic [2:0]              status,
  output logic [5:0]              hit_index,
  output logic [15:0]             hit_id,
  output logic [6:0]              entry_count
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SEL_W = (CNT_W > 6) ? CNT_W : 6;
  localparam int OUT_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  // table memory, one write and one registered read per cycle
  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  // control state
  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             rd_vld, rd_vld_next;
  logic             done_next;

  // working registers of the current request
  logic [CNT_W-1:0] ptr, ptr_next;          // issue pointer (shift: destination)
  logic [CNT_W-1:0] le_cnt, le_cnt_next;    // entries with x <= new x, i.e. the slot
  logic             dup_seen, dup_seen_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;    // address of the data now in rd_q
  entry_t           q_entry, q_entry_next;
  logic signed [32:0] q_xr, q_xr_next;
  logic signed [32:0] q_yb, q_yb_next;
  logic [5:0]       q_start, q_start_next;

  // result registers
  logic [2:0]  status_next;
  logic [5:0]  hit_index_next;
  logic [15:0] hit_id_next;
  logic [6:0]  entry_count_next;

  probe_t     probe;
  cmp_flags_t flags;

  logic [SEL_W-1:0] idx_wide;
  logic [OUT_W-1:0] cnt_wide;
  logic [OUT_W-1:0] cnt_inc_wide;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] ptr_dec;

  assign probe.x   = q_entry.x;
  assign probe.y   = q_entry.y;
  assign probe.xr  = q_xr;
  assign probe.yb  = q_yb;
  assign probe.typ = q_entry.typ;
  assign probe.id  = q_entry.id;

  sbct_cmp u_cmp (
    .entry (rd_q),
    .probe (probe),
    .flags (flags)
  );

  assign busy         = (state != ST_IDLE);
  assign idx_wide     = SEL_W'(rd_idx);
  assign count_inc    = count + CNT_W'(1);
  assign cnt_wide     = OUT_W'(count);
  assign cnt_inc_wide = OUT_W'(count_inc);
  assign ptr_dec      = ptr - CNT_W'(1);

  always_comb begin
    state_next       = state;
    count_next       = count;
    rd_vld_next      = 1'b0;
    done_next        = 1'b0;
    ptr_next         = ptr;
    le_cnt_next      = le_cnt;
    dup_seen_next    = dup_seen;
    rd_idx_next      = rd_idx;
    q_entry_next     = q_entry;
    q_xr_next        = q_xr;
    q_yb_next        = q_yb;
    q_start_next     = q_start;
    status_next      = status;
    hit_index_next   = hit_index;
    hit_id_next      = hit_id;
    entry_count_next = entry_count;
    rd_addr          = ptr[IDX_W-1:0];
    mem_we           = 1'b0;
    waddr            = rd_idx;
    wdata            = rd_q;

    case (state)
      ST_IDLE: begin
        if (start) begin
          q_entry_next.x   = pos_x;
          q_entry_next.y   = pos_y;
          q_entry_next.w   = box_w;
          q_entry_next.h   = box_h;
          q_entry_next.typ = obj_type;
          q_entry_next.id  = obj_id;
          q_xr_next        = $signed(33'(pos_x)) + $signed({2'b00, box_w});
          q_yb_next        = $signed(33'(pos_y)) + $signed({2'b00, box_h});
          q_start_next     = start_index;
          dup_seen_next    = 1'b0;
          le_cnt_next      = '0;
          if (func == FUNC_INSERT) begin
            ptr_next   = '0;
            state_next = ST_INS_SCAN;
          end else if (SEL_W'(start_index) < SEL_W'(count)) begin
            ptr_next   = CNT_W'(start_index);
            state_next = ST_QRY_SCAN;
          end else begin
            // start at or past count: nothing to look at
            done_next        = 1'b1;
            status_next      = STAT_NO_HIT;
            hit_index_next   = start_index;
            hit_id_next      = '0;
            entry_count_next = cnt_wide[6:0];
          end
        end
      end

      ST_INS_SCAN: begin
        // stream every held entry through the compare unit
        if (ptr < count) begin
          rd_addr     = ptr[IDX_W-1:0];
          rd_idx_next = ptr[IDX_W-1:0];
          rd_vld_next = 1'b1;
          ptr_next    = count_inc == ptr ? ptr : ptr + CNT_W'(1);
        end
        if (rd_vld) begin
          if (flags.id_eq) dup_seen_next = 1'b1;
          if (flags.x_le)  le_cnt_next   = le_cnt + CNT_W'(1);
        end
        if (ptr == count && !rd_vld) begin
          if (dup_seen || count == FULL_COUNT) begin
            done_next        = 1'b1;
            status_next      = dup_seen ? STAT_DUPLICATE : STAT_FULL;
            hit_index_next   = '0;
            hit_id_next      = '0;
            entry_count_next = cnt_wide[6:0];
            state_next       = ST_IDLE;
          end else begin
            // ptr already equals count: first destination of the shift
            state_next = ST_INS_SHIFT;
          end
        end
      end

      ST_INS_SHIFT: begin
        // read entry d-1, write it to d on the next cycle, top down
        if (ptr > le_cnt) begin
          rd_addr     = ptr_dec[IDX_W-1:0];
          rd_idx_next = ptr_dec[IDX_W-1:0];
          rd_vld_next = 1'b1;
          ptr_next    = ptr_dec;
        end
        if (rd_vld) begin
          mem_we = 1'b1;
          waddr  = rd_idx + IDX_W'(1);
          wdata  = rd_q;
        end else if (ptr == le_cnt) begin
          // gap open: drop the new box into its slot
          mem_we           = 1'b1;
          waddr            = le_cnt[IDX_W-1:0];
          wdata            = q_entry;
          count_next       = count_inc;
          done_next        = 1'b1;
          status_next      = STAT_INSERTED;
          hit_index_next   = '0;
          hit_id_next      = '0;
          entry_count_next = cnt_inc_wide[6:0];
          state_next       = ST_IDLE;
        end
      end

      ST_QRY_SCAN: begin
        if (ptr < count) begin
          rd_addr     = ptr[IDX_W-1:0];
          rd_idx_next = ptr[IDX_W-1:0];
          rd_vld_next = 1'b1;
          ptr_next    = ptr + CNT_W'(1);
        end
        if (rd_vld && flags.type_eq && !flags.id_eq &&
            (flags.past_right || flags.overlap)) begin
          // first candidate that either lies beyond the right edge or overlaps
          done_next        = 1'b1;
          rd_vld_next      = 1'b0;
          entry_count_next = cnt_wide[6:0];
          state_next       = ST_IDLE;
          if (flags.past_right) begin
            status_next    = STAT_NO_HIT;
            hit_index_next = q_start;
            hit_id_next    = '0;
          end else begin
            status_next    = STAT_HIT;
            hit_index_next = idx_wide[5:0];
            hit_id_next    = rd_q.id;
          end
        end else if (ptr == count && !rd_vld) begin
          done_next        = 1'b1;
          status_next      = STAT_NO_HIT;
          hit_index_next   = q_start;
          hit_id_next      = '0;
          entry_count_next = cnt_wide[6:0];
          state_next       = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_vld <= rd_vld_next;
      done   <= done_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    ptr         <= ptr_next;
    le_cnt      <= le_cnt_next;
    dup_seen    <= dup_seen_next;
    rd_idx      <= rd_idx_next;
    q_entry     <= q_entry_next;
    q_xr        <= q_xr_next;
    q_yb        <= q_yb_next;
    q_start     <= q_start_next;
    status      <= status_next;
    hit_index   <= hit_index_next;
    hit_id      <= hit_id_next;
    entry_count <= entry_count_next;
  end

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== design/sbct_cmp.sv =====
// compare unit shared by insert and query scans
// depends on sbct_pkg
`default_nettype none

module sbct_cmp
  import sbct_pkg::*;
(
  input  wire entry_t  entry,
  input  wire probe_t  probe,
  output cmp_flags_t   flags
);

  logic signed [32:0] e_left;
  logic signed [32:0] e_right;
  logic signed [32:0] e_bottom;

  // exact 33 bit edges, no wrap
  assign e_left   = $signed(33'(entry.x));
  assign e_right  = $signed(33'(entry.x)) + $signed({2'b00, entry.w});
  assign e_bottom = $signed(33'(entry.y)) + $signed({2'b00, entry.h});

  assign flags.id_eq      = (entry.id == probe.id);
  assign flags.type_eq    = (entry.typ == probe.typ);
  assign flags.x_le       = (entry.x <= probe.x);
  assign flags.past_right = (e_left > probe.xr);
  assign flags.overlap    = ($signed(33'(probe.x)) < e_right) && (e_left < probe.xr) &&
                            ($signed(33'(probe.y)) < e_bottom) &&
                            ($signed(33'(entry.y)) < probe.yb);

endmodule

`default_nettype wire

// ===== design/sbct_checker.sv =====
// port-level checks for the sorted box collision table core, bound to the top
// depends on sbct_pkg and sorted_box_collision_table_core_defines.svh
`default_nettype none
`include "sorted_box_collision_table_core_defines.svh"

module sbct_checker
  import sbct_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [2:0]  status,
  input wire logic [5:0]  hit_index,
  input wire logic [15:0] hit_id
);

  // a query that starts at or past count answers at once without going busy
  `SBCT_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy || done, "accepted request neither raised busy nor gave a result")
  `SBCT_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result strobe while still busy")
  `SBCT_ASSERT_NOW(a_done_cause, clk, rst, done, $past(busy) || $past(start && !busy), "result without a request")
  `SBCT_ASSERT_NOW(a_insert_clean, clk, rst, done && status == STAT_INSERTED, hit_index == 6'd0 && hit_id == 16'd0, "insert result carries hit data")

endmodule

bind sorted_box_collision_table_core sbct_checker u_sbct_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .hit_index (hit_index),
  .hit_id    (hit_id)
);

`default_nettype wire
